// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the quaternion to Euler angle RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QTE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/qte_pkg.sv -----
// Types, constants and helper functions of the quaternion to Euler angle block.
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANG_TABLE_LEN = 24;

  localparam int SW = 35;
  localparam int XW = 37;
  localparam int ZW = 28;
  localparam int AW = 17;
  localparam int ABW = 28;
  localparam int NW = 58;
  localparam int RTW = 29;
  localparam int RW = 31;
  localparam int SQRT_STAGES = 29;

  localparam logic signed [SW-1:0] ONE_Q28 = 35'sd268435456;
  localparam logic [NW-1:0] ONE_Q56 = 58'd72057594037927936;
  localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [AW-1:0] PI_Q13 = 17'sd25736;
  localparam logic signed [AW-1:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [ZW-1:0] ROUND_Q24 = 28'sd1024;

  typedef struct packed {
    logic signed [SW-1:0] sinr;
    logic signed [SW-1:0] cosr;
    logic signed [SW-1:0] sinp;
    logic signed [SW-1:0] siny;
    logic signed [SW-1:0] cosy;
    logic                 clamp;
  } args_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:    r = 28'sd13176795;
      5'd1:    r = 28'sd7778716;
      5'd2:    r = 28'sd4110060;
      5'd3:    r = 28'sd2086331;
      5'd4:    r = 28'sd1047214;
      5'd5:    r = 28'sd524117;
      5'd6:    r = 28'sd262123;
      5'd7:    r = 28'sd131069;
      5'd8:    r = 28'sd65536;
      5'd9:    r = 28'sd32768;
      5'd10:   r = 28'sd16384;
      5'd11:   r = 28'sd8192;
      5'd12:   r = 28'sd4096;
      5'd13:   r = 28'sd2048;
      5'd14:   r = 28'sd1024;
      5'd15:   r = 28'sd512;
      5'd16:   r = 28'sd256;
      5'd17:   r = 28'sd128;
      5'd18:   r = 28'sd64;
      5'd19:   r = 28'sd32;
      5'd20:   r = 28'sd16;
      5'd21:   r = 28'sd8;
      5'd22:   r = 28'sd4;
      5'd23:   r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Flags a zero vector and moves a left half plane vector to the right half plane, starting z at +/-pi.
  function automatic vec_t cordic_prep(input logic signed [XW-1:0] y,
                                       input logic signed [XW-1:0] x);
    vec_t r;
    r.zero = (x == '0) && (y == '0);
    r.x = x;
    r.y = y;
    r.z = '0;
    if (x[XW-1]) begin
      r.z = y[XW-1] ? -PI_Q24 : PI_Q24;
      r.x = -x;
      r.y = -y;
    end
    return r;
  endfunction

  function automatic vec_t cordic_step(input vec_t v, input logic [4:0] i);
    vec_t r;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    xs = $signed(v.x) >>> i;
    ys = $signed(v.y) >>> i;
    r = v;
    if (!v.y[XW-1]) begin
      r.x = $signed(v.x) + ys;
      r.y = $signed(v.y) - xs;
      r.z = $signed(v.z) + atan_q24(i);
    end else begin
      r.x = $signed(v.x) - ys;
      r.y = $signed(v.y) + xs;
      r.z = $signed(v.z) - atan_q24(i);
    end
    return r;
  endfunction

  function automatic logic signed [AW-1:0] to_q13(input vec_t v,
                                                  input logic signed [AW-1:0] lim);
    logic signed [ZW-1:0] zr;
    logic signed [AW-1:0] a;
    zr = $signed(v.z) + ROUND_Q24;
    a = v.zero ? '0 : AW'(zr >>> 11);
    if (a > lim) begin
      a = lim;
    end else if (a < -lim) begin
      a = -lim;
    end
    return a;
  endfunction

endpackage

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// done is high when the item taken with start reaches the output registers.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// The depth is set by the product and argument registers, the 29-stage square root for pitch and the CORDIC stages.
// Reset clears the valid pipeline only; items in flight are dropped.
`include "assert_macros.svh"
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);

  localparam int NS = (CORDIC_STAGES < qte_pkg::ANG_TABLE_LEN) ?
                      CORDIC_STAGES : qte_pkg::ANG_TABLE_LEN;
  localparam int SQ = qte_pkg::SQRT_STAGES;
  localparam int LAT = SQ + NS + 7;
  localparam int SW = qte_pkg::SW;
  localparam int XW = qte_pkg::XW;
  localparam int NW = qte_pkg::NW;
  localparam int RTW = qte_pkg::RTW;
  localparam int RW = qte_pkg::RW;
  localparam int ABW = qte_pkg::ABW;

  logic [LAT-1:0] vld;

  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  qte_pkg::args_t s2_args;
  qte_pkg::args_t s3_args;
  logic [ABW-1:0] s3_abs;
  qte_pkg::args_t s4_args;
  logic [2*ABW-1:0] s4_sq;
  qte_pkg::args_t s5_args;
  logic [NW-1:0] s5_rad;

  logic [RTW-1:0] sq_root [1:SQ];
  logic [RW-1:0] sq_rem [1:SQ];
  logic [NW-1:0] sq_rad [1:SQ];
  qte_pkg::args_t sq_args [1:SQ];

  qte_pkg::vec_t cv_roll [0:NS];
  qte_pkg::vec_t cv_pitch [0:NS];
  qte_pkg::vec_t cv_yaw [0:NS];
  logic cl_clamp [0:NS];
  logic cl_pos [0:NS];

  logic signed [SW-1:0] sinp2;
  logic clamp_next;

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_wy <= quat_w * quat_y;
    p_zx <= quat_z * quat_x;
    p_wz <= quat_w * quat_z;
    p_xy <= quat_x * quat_y;
    p_zz <= quat_z * quat_z;
  end

  always_ff @(posedge clk) begin
    s2_args.sinr <= (SW'(p_wx) + SW'(p_yz)) <<< 1;
    s2_args.cosr <= qte_pkg::ONE_Q28 - ((SW'(p_xx) + SW'(p_yy)) <<< 1);
    s2_args.sinp <= (SW'(p_wy) - SW'(p_zx)) <<< 1;
    s2_args.siny <= (SW'(p_wz) + SW'(p_xy)) <<< 1;
    s2_args.cosy <= qte_pkg::ONE_Q28 - ((SW'(p_yy) + SW'(p_zz)) <<< 1);
    s2_args.clamp <= 1'b0;
  end

  assign sinp2 = $signed(s2_args.sinp);
  assign clamp_next = (sinp2 >= qte_pkg::ONE_Q28) || (sinp2 <= -qte_pkg::ONE_Q28);

  always_ff @(posedge clk) begin
    s3_args <= '{sinr: s2_args.sinr, cosr: s2_args.cosr, sinp: s2_args.sinp,
                 siny: s2_args.siny, cosy: s2_args.cosy, clamp: clamp_next};
    if (clamp_next) begin
      s3_abs <= '0;
    end else if (sinp2[SW-1]) begin
      s3_abs <= ABW'(-sinp2);
    end else begin
      s3_abs <= ABW'(sinp2);
    end
  end

  always_ff @(posedge clk) begin
    s4_args <= s3_args;
    s4_sq <= s3_abs * s3_abs;
  end

  always_ff @(posedge clk) begin
    s5_args <= s4_args;
    s5_rad <= qte_pkg::ONE_Q56 - NW'(s4_sq);
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sq
    logic [RTW-1:0] root_in;
    logic [RW-1:0] rem_in;
    logic [NW-1:0] rad_in;
    qte_pkg::args_t args_in;
    logic [RW+1:0] cand;
    logic [RW+1:0] trial;
    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in = '0;
      assign rad_in = s5_rad;
      assign args_in = s5_args;
    end else begin : g_rest
      assign root_in = sq_root[k];
      assign rem_in = sq_rem[k];
      assign rad_in = sq_rad[k];
      assign args_in = sq_args[k];
    end
    assign cand = {rem_in, rad_in[NW-1-2*k -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    always_ff @(posedge clk) begin
      if (cand >= trial) begin
        sq_rem[k+1] <= RW'(cand - trial);
        sq_root[k+1] <= {root_in[RTW-2:0], 1'b1};
      end else begin
        sq_rem[k+1] <= RW'(cand);
        sq_root[k+1] <= {root_in[RTW-2:0], 1'b0};
      end
      sq_rad[k+1] <= rad_in;
      sq_args[k+1] <= args_in;
    end
  end

  always_ff @(posedge clk) begin
    cv_roll[0] <= qte_pkg::cordic_prep(XW'($signed(sq_args[SQ].sinr)),
                                       XW'($signed(sq_args[SQ].cosr)));
    cv_yaw[0] <= qte_pkg::cordic_prep(XW'($signed(sq_args[SQ].siny)),
                                      XW'($signed(sq_args[SQ].cosy)));
    cv_pitch[0] <= qte_pkg::cordic_prep(XW'($signed(sq_args[SQ].sinp)),
                                        XW'($signed({1'b0, sq_root[SQ]})));
    cl_clamp[0] <= sq_args[SQ].clamp;
    cl_pos[0] <= !sq_args[SQ].sinp[SW-1];
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      cv_roll[i+1] <= qte_pkg::cordic_step(cv_roll[i], 5'(i));
      cv_pitch[i+1] <= qte_pkg::cordic_step(cv_pitch[i], 5'(i));
      cv_yaw[i+1] <= qte_pkg::cordic_step(cv_yaw[i], 5'(i));
      cl_clamp[i+1] <= cl_clamp[i];
      cl_pos[i+1] <= cl_pos[i];
    end
  end

  always_ff @(posedge clk) begin
    roll_angle <= 16'(qte_pkg::to_q13(cv_roll[NS], qte_pkg::PI_Q13));
    yaw_angle <= 16'(qte_pkg::to_q13(cv_yaw[NS], qte_pkg::PI_Q13));
    pitch_clamped <= cl_clamp[NS];
    if (cl_clamp[NS]) begin
      pitch_angle <= cl_pos[NS] ? 15'(qte_pkg::HALF_PI_Q13) : 15'(-qte_pkg::HALF_PI_Q13);
    end else begin
      pitch_angle <= 15'(qte_pkg::to_q13(cv_pitch[NS], qte_pkg::HALF_PI_Q13));
    end
  end

  `QTE_ASSERT_IMPL(a_done_latency, clk, rst, done, $past(start, LAT))
  `QTE_ASSERT_NEXT(a_last_stage, clk, rst, vld[LAT-2], done)
  `QTE_ASSERT_IMPL(a_clamp_pitch, clk, rst, done && pitch_clamped, pitch_angle == 15'(qte_pkg::HALF_PI_Q13) || pitch_angle == 15'(-qte_pkg::HALF_PI_Q13))
  `QTE_ASSERT_IMPL(a_roll_range, clk, rst, done, roll_angle <= 16'(qte_pkg::PI_Q13) && roll_angle >= 16'(-qte_pkg::PI_Q13))

endmodule
